// ===== src/kfse_pkg.sv =====
`default_nettype none

package kfse_pkg;

    // default sizes
    localparam int MAX_KEYS_DEF = 64;
    localparam int LANES_DEF    = 4;

    // fixed field widths
    localparam int VAL_W   = 32;
    localparam int PADDR_W = 4;
    localparam int PDATA_W = 32;

    // shared divider: a Q0.16 ratio of Q16.16 differences needs a 48-bit dividend
    localparam int DVD_W  = 48;
    localparam int DVS_W  = 32;
    localparam int QUOT_W = 16;

    typedef enum logic [1:0] {
        MODE_CLEAR  = 2'd0,
        MODE_INSERT = 2'd1,
        MODE_EVAL   = 2'd2,
        MODE_IGNORE = 2'd3
    } kfse_mode_t;

    typedef enum logic [2:0] {
        STAT_EVAL    = 3'd0,
        STAT_CLEARED = 3'd1,
        STAT_STORED  = 3'd2,
        STAT_DUP     = 3'd3,
        STAT_FULL    = 3'd4
    } kfse_status_t;

    typedef enum logic [1:0] {
        BND_NONE  = 2'd0,
        BND_CLAMP = 2'd1,
        BND_LOOP  = 2'd2
    } kfse_bounds_t;

    typedef enum logic [1:0] {
        REG_LOOP_START  = 2'd0,
        REG_LOOP_LENGTH = 2'd1,
        REG_BOUNDS_MODE = 2'd2,
        REG_TENSION     = 2'd3
    } kfse_reg_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_EV_BOUND,
        ST_BOUND_DIV,
        ST_SRCH,
        ST_SRCH_CMP,
        ST_SH_RD,
        ST_SH_WR,
        ST_INS_WR,
        ST_HIT_CAP,
        ST_ROW_RD,
        ST_S_DIV,
        ST_S_SQ,
        ST_S_CUBE,
        ST_H_CALC,
        ST_TAN_MUL,
        ST_TAN_SUM,
        ST_MAC_MUL,
        ST_MAC_ACC,
        ST_LANE_DONE,
        ST_EMIT
    } kfse_state_t;

    typedef struct packed {
        logic [1:0]        mode;
        logic signed [31:0] frame;
        logic signed [31:0] value_0;
        logic signed [31:0] value_1;
        logic signed [31:0] value_2;
        logic signed [31:0] value_3;
    } kfse_cmd_t;

    typedef struct packed {
        logic [2:0]         status;
        logic               valid_res;
        logic signed [31:0] result_0;
        logic signed [31:0] result_1;
        logic signed [31:0] result_2;
        logic signed [31:0] result_3;
    } kfse_rsp_t;

    typedef struct packed {
        logic             start;
        logic [DVD_W-1:0] dividend;
        logic [DVS_W-1:0] divisor;
    } kfse_div_req_t;

    typedef struct packed {
        logic              done;
        logic [QUOT_W-1:0] quot;
        logic [DVS_W-1:0]  rem;
    } kfse_div_rsp_t;

    function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
        if (x > 64'sd2147483647) begin
            return 32'sh7fffffff;
        end
        else if (x < -64'sd2147483648) begin
            return 32'sh80000000;
        end
        else begin
            return x[31:0];
        end
    endfunction

endpackage

`default_nettype wire

// ===== src/kfse_div.sv =====
`default_nettype none

module kfse_div (
    input  logic                    clk,
    input  logic                    rst_n,
    input  kfse_pkg::kfse_div_req_t req,
    output kfse_pkg::kfse_div_rsp_t rsp
);
    import kfse_pkg::*;

    localparam int CNT_W = $clog2(DVD_W);

    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [DVD_W-1:0] dvd_reg;
    logic [DVS_W-1:0] rem_reg;
    logic [DVS_W-1:0] dvs_reg;
    logic [DVS_W:0]   part;
    logic [DVS_W:0]   trial;
    logic             ge;

    // restoring step: one quotient bit per cycle
    assign part  = {rem_reg, dvd_reg[DVD_W-1]};
    assign ge    = part >= {1'b0, dvs_reg};
    assign trial = part - {1'b0, dvs_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (req.start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + CNT_W'(1);
            if (cnt_reg == CNT_W'(DVD_W - 1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            dvd_reg <= req.dividend;
            dvs_reg <= req.divisor;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            dvd_reg <= {dvd_reg[DVD_W-2:0], ge};
            rem_reg <= ge ? trial[DVS_W-1:0] : part[DVS_W-1:0];
        end
    end

    assign rsp.done = done_reg;
    assign rsp.quot = dvd_reg[QUOT_W-1:0];
    assign rsp.rem  = rem_reg;

endmodule

`default_nettype wire

// ===== src/keyframe_spline_evaluator_top.sv =====
`default_nettype none

// Keyframe spline evaluator. Holds up to MAX_KEYS animation keys (a Q16.16 frame
// time plus LANES Q16.16 values) sorted by time in one key memory with a
// registered read. A cmd item clears the table, inserts a key, evaluates the
// cardinal spline at a frame, or is ignored; every item gives exactly one rsp
// item. One item is worked at a time and cmd_stall stays high until its result
// has moved into the output register, so the next item can enter while that
// result waits. An insert runs a binary search and then shifts each later key
// up one entry, by a read and a write through the memory port. An evaluate on a
// key or outside the keys runs the search and reads one row; an interpolated
// evaluate reads four rows, divides in the bit-serial divider and works the
// lanes one after another through tangents and accumulate. Loop wrapping of an
// out-of-range frame adds another pass of the same divider. The table needs no
// clearing pass after reset. Registers sit on an APB port at byte addresses 0, 4,
// 8, 12; the user must write them only while the block is idle, which is not enforced.

module keyframe_spline_evaluator_top #(
    parameter int MAX_KEYS = kfse_pkg::MAX_KEYS_DEF,
    parameter int LANES    = kfse_pkg::LANES_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cmd_valid,
    output logic                             cmd_stall,
    input  kfse_pkg::kfse_cmd_t              cmd,
    output logic                             rsp_valid,
    input  logic                             rsp_stall,
    output kfse_pkg::kfse_rsp_t              rsp,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [kfse_pkg::PADDR_W-1:0]     paddr,
    input  logic [kfse_pkg::PDATA_W-1:0]     pwdata,
    output logic [kfse_pkg::PDATA_W-1:0]     prdata,
    output logic                             pready
);
    import kfse_pkg::*;

    localparam int AW    = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;
    localparam int CW    = $clog2(MAX_KEYS + 1);
    localparam int LW    = (LANES > 1) ? $clog2(LANES) : 1;
    localparam int LN_W  = VAL_W * LANES;
    localparam int ROW_W = VAL_W + LN_W;
    localparam int RIW   = 2;

    // ---------------- configuration registers ----------------
    logic signed [31:0] start_reg;
    logic [30:0]        length_reg;
    logic [1:0]         bounds_reg;
    logic signed [31:0] tension_reg;
    logic               cfg_we;

    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_reg   <= '0;
            length_reg  <= '0;
            bounds_reg  <= '0;
            tension_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (kfse_reg_t'(paddr[3:2]))
                REG_LOOP_START:  start_reg   <= pwdata;
                REG_LOOP_LENGTH: length_reg  <= pwdata[30:0];
                REG_BOUNDS_MODE: bounds_reg  <= pwdata[1:0];
                REG_TENSION:     tension_reg <= pwdata;
            endcase
        end
    end

    always_comb
    begin
        unique case (kfse_reg_t'(paddr[3:2]))
            REG_LOOP_START:  prdata = start_reg;
            REG_LOOP_LENGTH: prdata = {1'b0, length_reg};
            REG_BOUNDS_MODE: prdata = {30'b0, bounds_reg};
            REG_TENSION:     prdata = tension_reg;
        endcase
    end

    // ---------------- state ----------------
    kfse_state_t state_reg, state_next;

    kfse_cmd_t          item_reg;
    logic signed [32:0] frame_reg;      // 33 bits: clamp to start+length can pass 2^31
    logic [CW-1:0]      count_reg;
    logic [CW-1:0]      lo_reg;
    logic [CW-1:0]      hi_reg;
    logic [AW-1:0]      mid_reg;
    logic               eq_reg;
    logic [CW-1:0]      j_reg;
    logic [2:0]         rd_cnt_reg;

    // neighbor rows of the interpolated segment
    logic [LN_W-1:0]    row_p_reg;
    logic [LN_W-1:0]    row_a_reg;
    logic [LN_W-1:0]    row_b_reg;
    logic [LN_W-1:0]    row_n_reg;
    logic signed [31:0] t0_reg;
    logic signed [31:0] t1_reg;

    logic [15:0]        s_reg;
    logic [15:0]        s2_reg;
    logic [15:0]        s3_reg;
    logic signed [19:0] h00_reg;
    logic signed [19:0] h01_reg;
    logic signed [19:0] h10_reg;
    logic signed [19:0] h11_reg;

    logic signed [48:0] ph_reg;
    logic signed [49:0] pl_reg;
    logic signed [31:0] ta_reg;
    logic signed [31:0] tb_reg;
    logic               tsel_reg;
    logic [1:0]         term_reg;
    logic [LW-1:0]      lane_reg;
    logic signed [51:0] prod_reg;
    logic signed [53:0] acc_reg;

    logic [2:0]         res_status_reg;
    logic               res_valid_reg;
    logic [31:0]        res_lane_reg [4];

    logic               rsp_valid_reg;
    kfse_rsp_t          rsp_reg;

    // key memory: time in the low word, lanes above
    logic [ROW_W-1:0]   key_mem [MAX_KEYS];
    logic [ROW_W-1:0]   rd_data_reg;
    logic [AW-1:0]      rd_addr;
    logic [AW-1:0]      wr_addr;
    logic [ROW_W-1:0]   wr_data;
    logic               mem_we;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            key_mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= key_mem[rd_addr];
    end

    // ---------------- divider ----------------
    kfse_div_req_t div_req;
    kfse_div_rsp_t div_rsp;
    logic          div_start;

    kfse_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // ---------------- datapath helpers ----------------
    logic               accept;
    logic signed [32:0] start_x;
    logic signed [32:0] end_x;
    logic               below;
    logic               above;
    logic signed [32:0] rel;
    logic signed [32:0] rel_neg;
    logic [31:0]        rel_mag;
    logic signed [32:0] rem_x;
    logic signed [32:0] wrapped;
    logic signed [32:0] dlt;
    logic signed [32:0] den;

    assign accept  = cmd_valid && !cmd_stall;
    assign start_x = {start_reg[31], start_reg};
    assign end_x   = start_x + $signed({2'b00, length_reg});
    assign below   = frame_reg < start_x;
    assign above   = frame_reg >= end_x;
    assign rel     = frame_reg - start_x;
    assign rel_neg = -rel;
    assign rel_mag = rel[32] ? rel_neg[31:0] : rel[31:0];
    // truncating remainder keeps the sign of the offset
    assign rem_x   = $signed({1'b0, div_rsp.rem});
    assign wrapped = start_x + (rel[32] ? -rem_x : rem_x);
    assign dlt     = frame_reg - {t0_reg[31], t0_reg};
    assign den     = {t1_reg[31], t1_reg} - {t0_reg[31], t0_reg};

    assign div_req.start    = div_start;
    assign div_req.dividend = (state_reg == ST_EV_BOUND) ? {16'b0, rel_mag}
                                                         : {dlt[31:0], 16'b0};
    assign div_req.divisor  = (state_reg == ST_EV_BOUND) ? {1'b0, length_reg}
                                                         : den[31:0];

    // search
    logic [CW:0]        mid_sum;
    logic [CW-1:0]      mid_w;
    logic signed [32:0] rd_time_x;
    logic               key_lt;
    logic               key_eq;

    assign mid_sum   = {1'b0, lo_reg} + {1'b0, hi_reg};
    assign mid_w     = mid_sum[CW:1];
    assign rd_time_x = {rd_data_reg[31], rd_data_reg[31:0]};
    assign key_lt    = rd_time_x < frame_reg;
    assign key_eq    = rd_time_x == frame_reg;

    logic [CW-1:0] lo_p1;
    logic [CW-1:0] lo_m1;
    logic [CW-1:0] lo_m2;
    logic [CW-1:0] cnt_m1;
    logic [CW-1:0] hit_idx;
    logic [CW-1:0] prev_idx;
    logic [CW-1:0] next_idx;
    logic          is_dup;
    logic          is_full;
    logic          is_hit;

    assign lo_p1    = lo_reg + CW'(1);
    assign lo_m1    = lo_reg - CW'(1);
    assign lo_m2    = lo_reg - CW'(2);
    assign cnt_m1   = count_reg - CW'(1);
    assign hit_idx  = (lo_reg == count_reg) ? cnt_m1 : lo_reg;
    // tangent neighbors wrap around the table
    assign prev_idx = (lo_reg == CW'(1)) ? cnt_m1 : lo_m2;
    assign next_idx = (lo_p1 < count_reg) ? lo_p1 : '0;
    assign is_dup   = (lo_reg < count_reg) && eq_reg;
    assign is_full  = count_reg >= CW'(MAX_KEYS);
    assign is_hit   = is_dup || (lo_reg == '0) || (lo_reg == count_reg);

    // insert row
    logic [3:0][31:0] vin;
    logic [LN_W-1:0]  ins_lanes;
    logic [ROW_W-1:0] ins_row;

    assign vin = {item_reg.value_3, item_reg.value_2, item_reg.value_1, item_reg.value_0};

    always_comb
    begin
        for (int l = 0; l < LANES; l++)
        begin
            ins_lanes[VAL_W*l +: VAL_W] = vin[l];
        end
    end

    assign ins_row = {ins_lanes, item_reg.frame};

    // spline basis
    logic [31:0]        sq;
    logic [31:0]        cube;
    logic signed [19:0] s_x;
    logic signed [19:0] s2_x;
    logic signed [19:0] s3_x;

    assign sq   = s_reg * s_reg;
    assign cube = s2_reg * s_reg;
    assign s_x  = $signed({4'b0, s_reg});
    assign s2_x = $signed({4'b0, s2_reg});
    assign s3_x = $signed({4'b0, s3_reg});

    // tangent factor k = floor((1 - tension) / 2), split in integer and fraction
    logic signed [32:0] kd;
    logic signed [32:0] kk;
    logic signed [15:0] kh;
    logic signed [16:0] kl;

    assign kd = 33'sd65536 - {tension_reg[31], tension_reg};
    assign kk = kd >>> 1;
    assign kh = kk[31:16];
    assign kl = $signed({1'b0, kk[15:0]});

    logic signed [31:0] lp;
    logic signed [31:0] la;
    logic signed [31:0] lb;
    logic signed [31:0] ln;
    logic signed [32:0] diff;
    logic signed [49:0] tan_sum;
    logic signed [31:0] tan;

    assign lp      = row_p_reg[VAL_W*lane_reg +: VAL_W];
    assign la      = row_a_reg[VAL_W*lane_reg +: VAL_W];
    assign lb      = row_b_reg[VAL_W*lane_reg +: VAL_W];
    assign ln      = row_n_reg[VAL_W*lane_reg +: VAL_W];
    assign diff    = tsel_reg ? ({ln[31], ln} - {la[31], la}) : ({lb[31], lb} - {lp[31], lp});
    assign tan_sum = 50'(ph_reg) + (pl_reg >>> 16);
    assign tan     = sat32(64'(tan_sum));

    logic signed [19:0] hsel;
    logic signed [31:0] xsel;
    logic signed [31:0] lane_out;

    always_comb
    begin
        unique case (term_reg)
            2'd0:
            begin
                hsel = h00_reg;
                xsel = la;
            end
            2'd1:
            begin
                hsel = h01_reg;
                xsel = lb;
            end
            2'd2:
            begin
                hsel = h10_reg;
                xsel = ta_reg;
            end
            2'd3:
            begin
                hsel = h11_reg;
                xsel = tb_reg;
            end
        endcase
    end

    assign lane_out = sat32(64'(acc_reg >>> 16));

    // ---------------- sequencer ----------------
    assign cmd_stall = (state_reg != ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        mem_we     = 1'b0;
        rd_addr    = '0;
        wr_addr    = '0;
        wr_data    = ins_row;
        div_start  = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    unique case (kfse_mode_t'(cmd.mode))
                        MODE_CLEAR:  state_next = ST_EMIT;
                        MODE_INSERT: state_next = ST_SRCH;
                        MODE_EVAL:   state_next = ST_EV_BOUND;
                        MODE_IGNORE: state_next = ST_EMIT;
                    endcase
                end
            end
            ST_EV_BOUND:
            begin
                if (count_reg == '0)
                begin
                    state_next = ST_EMIT;
                end
                else if (below || above)
                begin
                    priority if (bounds_reg == BND_CLAMP)
                    begin
                        state_next = ST_SRCH;
                    end
                    else if (bounds_reg == BND_LOOP && length_reg == '0)
                    begin
                        state_next = ST_SRCH;
                    end
                    else if (bounds_reg == BND_LOOP)
                    begin
                        div_start  = 1'b1;
                        state_next = ST_BOUND_DIV;
                    end
                    else
                    begin
                        state_next = ST_EMIT;
                    end
                end
                else
                begin
                    state_next = ST_SRCH;
                end
            end
            ST_BOUND_DIV:
            begin
                if (div_rsp.done)
                begin
                    state_next = ST_SRCH;
                end
            end
            ST_SRCH:
            begin
                if (lo_reg < hi_reg)
                begin
                    rd_addr    = mid_w[AW-1:0];
                    state_next = ST_SRCH_CMP;
                end
                else if (item_reg.mode == MODE_INSERT)
                begin
                    state_next = (is_dup || is_full) ? ST_EMIT : ST_SH_RD;
                end
                else if (is_hit)
                begin
                    rd_addr    = hit_idx[AW-1:0];
                    state_next = ST_HIT_CAP;
                end
                else
                begin
                    state_next = ST_ROW_RD;
                end
            end
            ST_SRCH_CMP:
            begin
                state_next = ST_SRCH;
            end
            ST_SH_RD:
            begin
                if (j_reg > lo_reg)
                begin
                    rd_addr    = AW'(j_reg - CW'(1));
                    state_next = ST_SH_WR;
                end
                else
                begin
                    state_next = ST_INS_WR;
                end
            end
            ST_SH_WR:
            begin
                mem_we     = 1'b1;
                wr_addr    = j_reg[AW-1:0];
                wr_data    = rd_data_reg;
                state_next = ST_SH_RD;
            end
            ST_INS_WR:
            begin
                mem_we     = 1'b1;
                wr_addr    = lo_reg[AW-1:0];
                state_next = ST_EMIT;
            end
            ST_HIT_CAP:
            begin
                state_next = ST_EMIT;
            end
            ST_ROW_RD:
            begin
                // rows issued in order: before-left, left, right, after-right
                unique case (rd_cnt_reg)
                    3'd0: rd_addr = prev_idx[AW-1:0];
                    3'd1: rd_addr = lo_m1[AW-1:0];
                    3'd2: rd_addr = lo_reg[AW-1:0];
                    3'd3: rd_addr = next_idx[AW-1:0];
                    3'd4:
                    begin
                        div_start  = 1'b1;
                        state_next = ST_S_DIV;
                    end
                    default: state_next = ST_S_DIV;
                endcase
            end
            ST_S_DIV:
            begin
                if (div_rsp.done)
                begin
                    state_next = ST_S_SQ;
                end
            end
            ST_S_SQ:      state_next = ST_S_CUBE;
            ST_S_CUBE:    state_next = ST_H_CALC;
            ST_H_CALC:    state_next = ST_TAN_MUL;
            ST_TAN_MUL:   state_next = ST_TAN_SUM;
            ST_TAN_SUM:   state_next = tsel_reg ? ST_MAC_MUL : ST_TAN_MUL;
            ST_MAC_MUL:   state_next = ST_MAC_ACC;
            ST_MAC_ACC:   state_next = (term_reg == 2'd3) ? ST_LANE_DONE : ST_MAC_MUL;
            ST_LANE_DONE: state_next = (lane_reg == LW'(LANES - 1)) ? ST_EMIT : ST_TAN_MUL;
            ST_EMIT:
            begin
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    state_next = ST_IDLE;
                end
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (accept && cmd.mode == MODE_CLEAR)
            begin
                count_reg <= '0;
            end
            else if (state_reg == ST_INS_WR)
            begin
                count_reg <= count_reg + CW'(1);
            end
            if (state_reg == ST_EMIT && (!rsp_valid_reg || !rsp_stall))
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (!rsp_stall)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    item_reg       <= cmd;
                    frame_reg      <= {cmd.frame[31], cmd.frame};
                    lo_reg         <= '0;
                    hi_reg         <= count_reg;
                    eq_reg         <= 1'b0;
                    res_status_reg <= (cmd.mode == MODE_CLEAR) ? STAT_CLEARED : STAT_EVAL;
                    res_valid_reg  <= 1'b0;
                    for (int l = 0; l < 4; l++)
                    begin
                        res_lane_reg[l] <= '0;
                    end
                end
            end
            ST_EV_BOUND:
            begin
                if (below || above)
                begin
                    if (bounds_reg == BND_CLAMP)
                    begin
                        frame_reg <= below ? start_x : end_x;
                    end
                    else if (bounds_reg == BND_LOOP && length_reg == '0)
                    begin
                        frame_reg <= start_x;
                    end
                end
            end
            ST_BOUND_DIV:
            begin
                if (div_rsp.done)
                begin
                    frame_reg <= wrapped;
                end
            end
            ST_SRCH:
            begin
                if (lo_reg < hi_reg)
                begin
                    mid_reg <= mid_w[AW-1:0];
                end
                else
                begin
                    j_reg      <= count_reg;
                    rd_cnt_reg <= '0;
                    if (item_reg.mode == MODE_INSERT)
                    begin
                        if (is_dup)
                        begin
                            res_status_reg <= STAT_DUP;
                        end
                        else if (is_full)
                        begin
                            res_status_reg <= STAT_FULL;
                        end
                    end
                end
            end
            ST_SRCH_CMP:
            begin
                // last key at or above the frame also tells an exact hit
                if (key_lt)
                begin
                    lo_reg <= CW'(mid_reg) + CW'(1);
                end
                else
                begin
                    hi_reg <= CW'(mid_reg);
                    eq_reg <= key_eq;
                end
            end
            ST_SH_RD:
            begin
            end
            ST_SH_WR:
            begin
                j_reg <= j_reg - CW'(1);
            end
            ST_INS_WR:
            begin
                res_status_reg <= STAT_STORED;
            end
            ST_HIT_CAP:
            begin
                res_valid_reg <= 1'b1;
                for (int l = 0; l < LANES; l++)
                begin
                    res_lane_reg[l] <= rd_data_reg[VAL_W*(l+1) +: VAL_W];
                end
            end
            ST_ROW_RD:
            begin
                rd_cnt_reg <= rd_cnt_reg + 3'd1;
                unique case (rd_cnt_reg)
                    3'd1: row_p_reg <= rd_data_reg[ROW_W-1:VAL_W];
                    3'd2:
                    begin
                        row_a_reg <= rd_data_reg[ROW_W-1:VAL_W];
                        t0_reg    <= rd_data_reg[VAL_W-1:0];
                    end
                    3'd3:
                    begin
                        row_b_reg <= rd_data_reg[ROW_W-1:VAL_W];
                        t1_reg    <= rd_data_reg[VAL_W-1:0];
                    end
                    3'd4: row_n_reg <= rd_data_reg[ROW_W-1:VAL_W];
                    default:
                    begin
                    end
                endcase
            end
            ST_S_DIV:
            begin
                if (div_rsp.done)
                begin
                    s_reg <= div_rsp.quot;
                end
            end
            ST_S_SQ:
            begin
                s2_reg <= sq[31:16];
            end
            ST_S_CUBE:
            begin
                s3_reg <= cube[31:16];
            end
            ST_H_CALC:
            begin
                h00_reg  <= (s3_x <<< 1) - (s2_x + (s2_x <<< 1)) + 20'sd65536;
                h01_reg  <= (s2_x + (s2_x <<< 1)) - (s3_x <<< 1);
                h10_reg  <= s3_x - (s2_x <<< 1) + s_x;
                h11_reg  <= s3_x - s2_x;
                lane_reg <= '0;
                tsel_reg <= 1'b0;
            end
            ST_TAN_MUL:
            begin
                ph_reg <= kh * diff;
                pl_reg <= kl * diff;
            end
            ST_TAN_SUM:
            begin
                if (!tsel_reg)
                begin
                    ta_reg   <= tan;
                    tsel_reg <= 1'b1;
                end
                else
                begin
                    tb_reg   <= tan;
                    term_reg <= 2'd0;
                    acc_reg  <= '0;
                end
            end
            ST_MAC_MUL:
            begin
                prod_reg <= hsel * xsel;
            end
            ST_MAC_ACC:
            begin
                acc_reg  <= acc_reg + 54'(prod_reg);
                term_reg <= term_reg + 2'd1;
            end
            ST_LANE_DONE:
            begin
                res_lane_reg[RIW'(lane_reg)] <= lane_out;
                lane_reg <= lane_reg + LW'(1);
                tsel_reg <= 1'b0;
                if (lane_reg == LW'(LANES - 1))
                begin
                    res_valid_reg <= 1'b1;
                end
            end
            ST_EMIT:
            begin
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    rsp_reg.status    <= res_status_reg;
                    rsp_reg.valid_res <= res_valid_reg;
                    rsp_reg.result_0  <= res_lane_reg[0];
                    rsp_reg.result_1  <= res_lane_reg[1];
                    rsp_reg.result_2  <= res_lane_reg[2];
                    rsp_reg.result_3  <= res_lane_reg[3];
                end
            end
        endcase
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // ---------------- checks ----------------
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(MAX_KEYS))
        else $error("key count beyond table size");

    a_write_in_table: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> (CW'(wr_addr) <= count_reg) && !is_full)
        else $error("key write outside the filled table");

    a_div_expected: assert property (@(posedge clk) disable iff (!rst_n)
        div_rsp.done |-> (state_reg == ST_BOUND_DIV || state_reg == ST_S_DIV))
        else $error("divider finished with no one waiting");

    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_valid && !cmd_stall) |=> cmd_stall)
        else $error("second item taken while one is in work");

endmodule

`default_nettype wire

// ===== sim/keyframe_spline_evaluator_top_tb.sv =====
module keyframe_spline_evaluator_top_tb;
    import kfse_pkg::*;

    // key table tracker: mirrors the sorted keys and the registers, predicts each result
    class key_table_board;
        longint key_t[64];
        longint key_v[64][4];
        int     key_n;
        longint start_q;
        longint length_q;
        logic [1:0] bounds_q;
        longint tension_q;
        kfse_rsp_t expected_q[$];
        int unsigned errors;
        int unsigned checked;
        int unsigned interpolated;

        function new();
            key_n = 0;
            start_q = 0;
            length_q = 0;
            bounds_q = BND_NONE;
            tension_q = 0;
            errors = 0;
            checked = 0;
            interpolated = 0;
        endfunction

        function void set_reg(kfse_reg_t idx, logic [31:0] data);
            case (idx)
                REG_LOOP_START:  start_q = longint'($signed(data));
                REG_LOOP_LENGTH: length_q = longint'(data[30:0]);
                REG_BOUNDS_MODE: bounds_q = data[1:0];
                default:         tension_q = longint'($signed(data));
            endcase
        endfunction

        function longint sat(longint x);
            if (x > 64'sd2147483647) return 64'sd2147483647;
            if (x < -64'sd2147483648) return -64'sd2147483648;
            return x;
        endfunction

        // first key at or after f
        function int first_not_below(longint f);
            int lo;
            int hi;
            int mid;
            lo = 0;
            hi = key_n;
            while (lo < hi) begin
                mid = lo + (hi - lo) / 2;
                if (key_t[mid] < f) lo = mid + 1;
                else hi = mid;
            end
            return lo;
        endfunction

        function longint slope_at(int i, int l);
            int     prv;
            int     nxt;
            longint diff;
            longint d;
            longint k;
            longint kh;
            longint kl;
            prv = (i != 0) ? i - 1 : key_n - 1;
            nxt = (i + 1 < key_n) ? i + 1 : 0;
            diff = key_v[nxt][l] - key_v[prv][l];
            d = 65536 - tension_q;
            k = d >>> 1;
            kh = k >>> 16;
            kl = k - (kh <<< 16);
            return sat(kh * diff + ((kl * diff) >>> 16));
        endfunction

        function kfse_rsp_t spline_result(kfse_cmd_t c);
            kfse_rsp_t r;
            longint f;
            longint stop;
            longint t0;
            longint t1;
            longint s;
            longint s2;
            longint s3;
            longint h00;
            longint h01;
            longint h10;
            longint h11;
            longint acc;
            longint lanes[4];
            int idx;
            int k;
            r = '0;
            lanes = '{0, 0, 0, 0};
            f = longint'(c.frame);
            case (c.mode)
                MODE_CLEAR:
                begin
                    key_n = 0;
                    r.status = STAT_CLEARED;
                end
                MODE_INSERT:
                begin
                    idx = first_not_below(f);
                    if (idx < key_n && key_t[idx] == f) begin
                        r.status = STAT_DUP;
                    end
                    else if (key_n >= 64) begin
                        r.status = STAT_FULL;
                    end
                    else begin
                        for (int j = key_n; j > idx; j--) begin
                            key_t[j] = key_t[j - 1];
                            key_v[j] = key_v[j - 1];
                        end
                        key_t[idx] = f;
                        key_v[idx][0] = longint'(c.value_0);
                        key_v[idx][1] = longint'(c.value_1);
                        key_v[idx][2] = longint'(c.value_2);
                        key_v[idx][3] = longint'(c.value_3);
                        key_n++;
                        r.status = STAT_STORED;
                    end
                end
                MODE_EVAL:
                begin
                    r.status = STAT_EVAL;
                    stop = start_q + length_q;
                    if (key_n == 0) return r;
                    if (f < start_q || f >= stop) begin
                        if (bounds_q == BND_CLAMP) begin
                            f = (f < start_q) ? start_q : stop;
                        end
                        else if (bounds_q == BND_LOOP) begin
                            f = (length_q != 0) ? (f - start_q) % length_q + start_q : start_q;
                        end
                        else begin
                            return r;
                        end
                    end
                    idx = first_not_below(f);
                    r.valid_res = 1'b1;
                    if ((idx < key_n && key_t[idx] == f) || idx == 0 || idx == key_n) begin
                        k = (idx == key_n) ? key_n - 1 : idx;
                        for (int l = 0; l < 4; l++) lanes[l] = key_v[k][l];
                    end
                    else begin
                        interpolated++;
                        t0 = key_t[idx - 1];
                        t1 = key_t[idx];
                        s = ((f - t0) * 65536) / (t1 - t0);
                        s2 = (s * s) / 65536;
                        s3 = (s2 * s) / 65536;
                        h00 = 2 * s3 - 3 * s2 + 65536;
                        h01 = 3 * s2 - 2 * s3;
                        h10 = s3 - 2 * s2 + s;
                        h11 = s3 - s2;
                        for (int l = 0; l < 4; l++) begin
                            acc = h00 * key_v[idx - 1][l] + h01 * key_v[idx][l]
                                + h10 * slope_at(idx - 1, l) + h11 * slope_at(idx, l);
                            lanes[l] = sat(acc >>> 16);
                        end
                    end
                end
                default:
                begin
                    r.status = STAT_EVAL;
                end
            endcase
            r.result_0 = lanes[0][31:0];
            r.result_1 = lanes[1][31:0];
            r.result_2 = lanes[2][31:0];
            r.result_3 = lanes[3][31:0];
            return r;
        endfunction

        function void note_cmd(kfse_cmd_t c);
            expected_q.push_back(spline_result(c));
        endfunction

        function void check_rsp(kfse_rsp_t got);
            kfse_rsp_t exp_r;
            if (expected_q.size() == 0) begin
                $error("unexpected result item: status %0d", got.status);
                errors++;
                return;
            end
            exp_r = expected_q.pop_front();
            checked++;
            if (got.status !== exp_r.status) begin
                $error("status: expected %0d, actual %0d", exp_r.status, got.status);
                errors++;
            end
            if (got.valid_res !== exp_r.valid_res) begin
                $error("valid_res: expected %0d, actual %0d", exp_r.valid_res, got.valid_res);
                errors++;
            end
            if (got.result_0 !== exp_r.result_0) begin
                $error("result_0: expected %0d, actual %0d", exp_r.result_0, got.result_0);
                errors++;
            end
            if (got.result_1 !== exp_r.result_1) begin
                $error("result_1: expected %0d, actual %0d", exp_r.result_1, got.result_1);
                errors++;
            end
            if (got.result_2 !== exp_r.result_2) begin
                $error("result_2: expected %0d, actual %0d", exp_r.result_2, got.result_2);
                errors++;
            end
            if (got.result_3 !== exp_r.result_3) begin
                $error("result_3: expected %0d, actual %0d", exp_r.result_3, got.result_3);
                errors++;
            end
        endfunction
    endclass

    localparam int unsigned CYCLE_LIMIT = 6000000;
    localparam int HOLD_CYCLES = 500;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cmd_valid = 1'b0;
    logic cmd_stall;
    kfse_cmd_t cmd = '0;
    logic rsp_valid;
    logic rsp_stall = 1'b0;
    kfse_rsp_t rsp;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [PADDR_W-1:0] paddr = '0;
    logic [PDATA_W-1:0] pwdata = '0;
    logic [PDATA_W-1:0] prdata;
    logic pready;

    key_table_board board = new();

    // idling knobs, percent per cycle
    int idle_pct = 0;
    int stall_pct = 0;
    // long receiver hold-off request, consumed by the receiver process
    bit hold_req = 1'b0;
    int hold_left = 0;
    // frame window used by the random items (Q16.16)
    int win_base = -(8 <<< 16);
    int unsigned win_span = 16 << 16;
    int unsigned cycles = 0;
    int unsigned items_sent = 0;

    keyframe_spline_evaluator_top i_dut (
        .clk(clk), .rst_n(rst_n),
        .cmd_valid(cmd_valid), .cmd_stall(cmd_stall), .cmd(cmd),
        .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // watchdog
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycles, board.expected_q.size());
            $display("Mismatches found");
            $finish;
        end
    end

    // receiver: random stall, or a long hold-off counted here
    always @(posedge clk)
    begin
        if (hold_req) begin
            hold_left = HOLD_CYCLES;
            hold_req = 1'b0;
        end
        if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
        end
        else begin
            rsp_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    // result monitor: values seen here are the ones in force at this edge
    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && !rsp_stall) board.check_rsp(rsp);
    end

    // offer one item, with random idle cycles ahead of it, and wait for acceptance
    task automatic send_item(kfse_cmd_t c);
        while ($urandom_range(99) < idle_pct) begin
            cmd_valid <= 1'b0;
            @(posedge clk);
        end
        cmd <= c;
        cmd_valid <= 1'b1;
        do @(posedge clk); while (cmd_stall);
        board.note_cmd(c);
        items_sent++;
    endtask

    // sender goes quiet until every expected result has come back
    task automatic drain();
        cmd_valid <= 1'b0;
        while (board.expected_q.size() != 0) @(posedge clk);
    endtask

    task automatic apb_write(kfse_reg_t idx, logic [31:0] data);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= data;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        board.set_reg(idx, data);
    endtask

    // registers change only with the block idle
    task automatic set_regs(logic [31:0] st, logic [31:0] len, kfse_bounds_t bm,
                            logic [31:0] ten);
        drain();
        repeat (60) @(posedge clk);
        apb_write(REG_LOOP_START, st);
        apb_write(REG_LOOP_LENGTH, len);
        apb_write(REG_BOUNDS_MODE, {30'd0, bm});
        apb_write(REG_TENSION, ten);
    endtask

    function automatic kfse_cmd_t make_cmd(kfse_mode_t m, logic [31:0] f,
                                           logic [31:0] a, logic [31:0] b,
                                           logic [31:0] c, logic [31:0] d);
        kfse_cmd_t x;
        x.mode = m;
        x.frame = f;
        x.value_0 = a;
        x.value_1 = b;
        x.value_2 = c;
        x.value_3 = d;
        return x;
    endfunction

    function automatic logic [31:0] rand_frame();
        int p;
        p = $urandom_range(9);
        if (p == 0) return $urandom;
        // grid frames give exact hits and duplicate inserts
        if (p < 3) return win_base + ($urandom_range(win_span >> 16) << 16);
        return win_base + $urandom_range(win_span);
    endfunction

    function automatic logic [31:0] rand_lane();
        if ($urandom_range(3) == 0) return $urandom;
        return $urandom_range(32'h0040_0000) - 32'h0020_0000;
    endfunction

    function automatic kfse_cmd_t rand_cmd(int insert_pct);
        int r;
        kfse_mode_t m;
        r = $urandom_range(99);
        if (r < 2) m = MODE_CLEAR;
        else if (r < 4) m = MODE_IGNORE;
        else if (r < 4 + insert_pct) m = MODE_INSERT;
        else m = MODE_EVAL;
        return make_cmd(m, rand_frame(), rand_lane(), rand_lane(), rand_lane(), rand_lane());
    endfunction

    task automatic random_items(int count, int insert_pct);
        for (int i = 0; i < count; i++) send_item(rand_cmd(insert_pct));
    endtask

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty table, then reset config where every frame is out of range
        send_item(make_cmd(MODE_EVAL, 32'd0, '0, '0, '0, '0));
        send_item(make_cmd(MODE_INSERT, 32'd0, 32'h7fffffff, 32'h80000000,
                           32'hffffffff, 32'd0));
        send_item(make_cmd(MODE_EVAL, 32'd0, '0, '0, '0, '0));
        send_item(make_cmd(MODE_CLEAR, '0, '0, '0, '0, '0));
        // widest range, bounds none: ends of the frame field
        set_regs(32'h80000000, 32'h7fffffff, BND_NONE, 32'd0);
        send_item(make_cmd(MODE_INSERT, 32'h80000000, 32'h7fffffff, 32'h80000000,
                           32'h00010000, 32'hffff0000));
        send_item(make_cmd(MODE_INSERT, 32'h7ffffffe, 32'h80000000, 32'h7fffffff,
                           32'hfffe0000, 32'h00020000));
        send_item(make_cmd(MODE_INSERT, 32'h00010000, 32'h12345678, 32'hedcba987,
                           32'd0, 32'hffffffff));
        send_item(make_cmd(MODE_INSERT, 32'h00010000, 32'd1, 32'd1, 32'd1, 32'd1));
        send_item(make_cmd(MODE_EVAL, 32'h80000000, '0, '0, '0, '0));
        send_item(make_cmd(MODE_EVAL, 32'h7ffffffe, '0, '0, '0, '0));
        send_item(make_cmd(MODE_EVAL, 32'h7fffffff, '0, '0, '0, '0));
        send_item(make_cmd(MODE_EVAL, 32'h00008000, '0, '0, '0, '0));
        send_item(make_cmd(MODE_EVAL, 32'hc0000000, '0, '0, '0, '0));
        send_item(make_cmd(MODE_EVAL, 32'h40000000, '0, '0, '0, '0));
        send_item(make_cmd(MODE_IGNORE, 32'hffffffff, 32'hffffffff, 32'hffffffff,
                           32'hffffffff, 32'hffffffff));
        // short range: before and after the range, clamp and loop of a negative frame
        set_regs(32'h00000000, 32'h00020000, BND_CLAMP, 32'h7fffffff);
        send_item(make_cmd(MODE_EVAL, 32'hffff0000, '0, '0, '0, '0));
        send_item(make_cmd(MODE_EVAL, 32'h00050000, '0, '0, '0, '0));
        set_regs(32'h00000000, 32'h00020000, BND_LOOP, 32'h80000000);
        send_item(make_cmd(MODE_EVAL, 32'hfffe8000, '0, '0, '0, '0));
        send_item(make_cmd(MODE_EVAL, 32'h00058000, '0, '0, '0, '0));
        set_regs(32'h00010000, 32'h00000000, BND_LOOP, 32'h00010000);
        send_item(make_cmd(MODE_EVAL, 32'h00070000, '0, '0, '0, '0));

        // clamp over a short range, no idling
        set_regs(32'hfffc0000, 32'h00080000, BND_CLAMP, 32'd0);
        idle_pct = 0;
        stall_pct = 0;
        send_item(make_cmd(MODE_CLEAR, '0, '0, '0, '0, '0));
        random_items(220, 40);

        // loop with zero tension factor, sender idle
        set_regs(32'hfffd0000, 32'h00058000, BND_LOOP, 32'h00010000);
        idle_pct = 84;
        random_items(220, 35);

        // zero length loop, receiver stalls, one long hold-off and a full drain
        set_regs(32'h00020000, 32'h00000000, BND_LOOP, 32'h80000000);
        idle_pct = 0;
        stall_pct = 84;
        random_items(100, 35);
        hold_req = 1'b1;
        random_items(60, 35);
        drain();
        random_items(90, 35);

        // widest range, fill the table past its limit, both sides idle
        set_regs(32'h80000000, 32'h7fffffff, BND_NONE, 32'h7fffffff);
        idle_pct = 35;
        stall_pct = 35;
        send_item(make_cmd(MODE_CLEAR, '0, '0, '0, '0, '0));
        win_base = -(40 <<< 16);
        win_span = 80 << 16;
        for (int i = 0; i < 72; i++) begin
            send_item(make_cmd(MODE_INSERT, rand_frame(), rand_lane(), rand_lane(),
                               rand_lane(), rand_lane()));
        end
        random_items(180, 20);

        // bounds code three acts as none; range end beyond 32 bits
        set_regs(32'h7fffffff, 32'h7fffffff, kfse_bounds_t'(2'd3), 32'h00008000);
        idle_pct = 0;
        stall_pct = 0;
        win_base = -(8 <<< 16);
        win_span = 16 << 16;
        random_items(200, 40);

        // loop over the widest range, mixed idling
        set_regs(32'h80000000, 32'h7fffffff, BND_LOOP, 32'hfffe0000);
        idle_pct = 20;
        stall_pct = 50;
        random_items(200, 40);

        drain();
        repeat (300) @(posedge clk);
        $display("%0d items sent, %0d results checked, %0d interpolated evaluations",
                 items_sent, board.checked, board.interpolated);
        $display("register settings covered clamp, loop, zero length and range extremes");
        if (board.errors == 0) begin
            $display("No mismatches found");
        end
        else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
src/kfse_pkg.sv
src/kfse_div.sv
src/keyframe_spline_evaluator_top.sv
sim/keyframe_spline_evaluator_top_tb.sv
